### design/fpao_pkg.sv
package fpao_pkg;

	localparam int DEF_PARTIALS   = 4;
	localparam int DEF_TABLE_BITS = 10;
	localparam int DEF_PHASE_BITS = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LANE_W     = 16;
	localparam int SINE_W     = 15;
	localparam int SAMPLE_W   = 16;
	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;
	localparam int ROUND_HALF = 1 << 29;
	localparam int MIX_SHIFT  = 30;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_VOL,
		ST_SAT
	} fpao_state_t;

	function automatic logic [LANE_W-1:0] lane(input logic [CFG_DATA_W-1:0] word,
			input logic [1:0] sel);
		return word[LANE_W*sel +: LANE_W];
	endfunction

endpackage

### design/four_partial_additive_oscillator_unit.sv
// Additive sine oscillator bank. Each accepted item (one tick, with an optional
// restart that reloads every phase from the start-phase register) yields one
// signed 16-bit sample: the sum over PARTIALS sine partials of sine(phase) times
// the partial's Q1.15 amplitude, scaled by the Q1.15 master volume, rounded and
// saturated. Each phase then advances by base_step times the partial's Q8.8
// ratio. Once an item is taken in idle, the phase memory is read and written
// once per cycle, one partial at a time; then the three-stage sine and
// amplitude pipeline drains, followed by a volume multiply and a rounding stage.
// A new item is taken only in idle, after the last sample has gone to the
// output register. A finished sample waits in that output register while the
// next item is taken; a held output stalls the next item in its rounding stage.
// Configuration writes are to take effect only between items; the block itself
// does not enforce this. Configuration writes never disturb the phases.
module four_partial_additive_oscillator_unit #(
	parameter int PARTIALS   = fpao_pkg::DEF_PARTIALS,
	parameter int TABLE_BITS = fpao_pkg::DEF_TABLE_BITS,
	parameter int PHASE_BITS = fpao_pkg::DEF_PHASE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fpao_pkg::SAMPLE_W-1:0] sample,
	input  logic                                cfg_we,
	input  logic [fpao_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpao_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fpao_pkg::*;

	localparam int IDX_W = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
	localparam int ACC_W = 31 + $clog2(PARTIALS);
	localparam int MUL_W = ACC_W + 16;
	localparam int RND_W = MUL_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTIALS - 1);

	fpao_state_t state_q, state_nxt;

	logic [31:0]           base_step_q;
	logic [CFG_DATA_W-1:0] ratio_q;
	logic [CFG_DATA_W-1:0] amp_q;
	logic [14:0]           volume_q;
	logic [CFG_DATA_W-1:0] start_q;

	logic [PHASE_BITS-1:0] phase_mem [PARTIALS];
	logic [PARTIALS-1:0]   phase_vld_q;

	logic             restart_q;
	logic [IDX_W-1:0] idx_q;
	logic             issue;
	logic             load_out;
	logic             in_acc;

	logic [47:0]           step_prod;
	logic [PHASE_BITS-1:0] rd_s1;
	logic [PHASE_BITS-1:0] inc_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  vld_s1;
	logic                  v_s1;

	logic [1:0]            lane_s1;
	logic [PHASE_BITS-1:0] start_ext;
	logic [PHASE_BITS-1:0] phase_cur;
	logic [PHASE_BITS-1:0] phase_nxt;
	logic [TABLE_BITS+1:0] top;
	logic [TABLE_BITS-1:0] rom_addr;
	logic [SINE_W-1:0]     rom_data;

	logic                     neg_s2;
	logic [LANE_W-1:0]        amp_s2;
	logic                     v_s2;
	logic signed [15:0]       sine_s2;
	logic signed [31:0]       prod_s3;
	logic                     v_s3;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [15:0]       vol_s;
	logic signed [MUL_W-1:0]  mul_q;
	logic signed [RND_W-1:0]  rnd;
	logic signed [RND_W-1:0]  shr;
	logic signed [SAMPLE_W-1:0] sample_nxt;
	logic                     out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q <= '0;
			ratio_q     <= '0;
			amp_q       <= '0;
			volume_q    <= '0;
			start_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_STEP:   base_step_q <= cfg_data[31:0];
				REG_RATIO:       ratio_q     <= cfg_data;
				REG_AMPLITUDE:   amp_q       <= cfg_data;
				REG_VOLUME:      volume_q    <= cfg_data[14:0];
				REG_START_PHASE: start_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					state_nxt = ST_VOL;
				end
			end
			ST_VOL: begin
				state_nxt = ST_SAT;
			end
			ST_SAT: begin
				if (!out_valid_q || out_ready) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			phase_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s1) begin
				phase_vld_q[idx_s1] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			restart_q <= restart;
		end
	end

	// read stage: fetch phase, form increment
	assign step_prod = 48'(base_step_q) * 48'(lane(ratio_q, 2'(idx_q)));

	always_ff @(posedge clk) begin
		rd_s1  <= phase_mem[idx_q];
		vld_s1 <= phase_vld_q[idx_q];
		inc_s1 <= step_prod[39 -: PHASE_BITS];
		idx_s1 <= idx_q;
		if (v_s1) begin
			phase_mem[idx_s1] <= phase_nxt;
		end
	end

	// modify stage: pick phase, write back, address the table
	always_comb begin
		lane_s1   = 2'(idx_s1);
		start_ext = PHASE_BITS'({lane(start_q, lane_s1), 16'b0} >> (32 - PHASE_BITS));
		if (restart_q) begin
			phase_cur = start_ext;
		end else if (vld_s1) begin
			phase_cur = rd_s1;
		end else begin
			phase_cur = '0;
		end
		phase_nxt = phase_cur + inc_s1;
		top       = phase_cur[PHASE_BITS-1 -: TABLE_BITS+2];
		rom_addr  = top[TABLE_BITS] ? ~top[TABLE_BITS-1:0] : top[TABLE_BITS-1:0];
	end

	fpao_sine_rom #(
		.TABLE_BITS(TABLE_BITS)
	) u_sine_rom (
		.clk (clk),
		.addr(rom_addr),
		.data(rom_data)
	);

	always_ff @(posedge clk) begin
		neg_s2 <= top[TABLE_BITS+1];
		amp_s2 <= lane(amp_q, lane_s1);
	end

	assign sine_s2 = neg_s2 ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

	always_ff @(posedge clk) begin
		prod_s3 <= sine_s2 * $signed(amp_s2);
		if (in_acc) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
	end

	// volume, round, saturate
	assign vol_s = $signed({1'b0, volume_q});

	always_ff @(posedge clk) begin
		if (state_q == ST_VOL) begin
			mul_q <= acc_q * vol_s;
		end
	end

	always_comb begin
		rnd = $signed({mul_q[MUL_W-1], mul_q}) + RND_W'(ROUND_HALF);
		shr = rnd >>> MIX_SHIFT;
		if (shr > SAMPLE_MAX) begin
			sample_nxt = SAMPLE_W'(SAMPLE_MAX);
		end else if (shr < SAMPLE_MIN) begin
			sample_nxt = SAMPLE_W'(SAMPLE_MIN);
		end else begin
			sample_nxt = SAMPLE_W'(shr);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sample_q <= sample_nxt;
		end
	end

	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("item taken while partial pipeline busy");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (acc_q == '0))
		else $error("accumulator not cleared for new item");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> $past(v_s2) && $past(v_s1, 2))
		else $error("partial pipeline valid out of order");

	a_out_from_sat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_SAT))
		else $error("sample presented outside saturation step");

endmodule

### design/fpao_sine_rom.sv
module fpao_sine_rom #(
	parameter int TABLE_BITS = fpao_pkg::DEF_TABLE_BITS
) (
	input  logic                         clk,
	input  logic [TABLE_BITS-1:0]        addr,
	output logic [fpao_pkg::SINE_W-1:0]  data
);
	import fpao_pkg::*;

	localparam int TABLE_LEN = 1 << TABLE_BITS;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [SINE_W-1:0] rom_arr_t [TABLE_LEN];

	// sin of a Q30 angle in [0, pi/2], Taylor series to x^15
	function automatic logic [63:0] sine_q30(input logic [63:0] a);
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] sum;
		a2   = (a * a) >> 30;
		term = a;
		sum  = a;
		for (int n = 1; n <= 7; n++) begin
			term = (term * a2) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	function automatic rom_arr_t build_rom();
		rom_arr_t    r;
		logic [63:0] a;
		logic [63:0] s;
		for (int k = 0; k < TABLE_LEN; k++) begin
			a = (HALF_PI_Q30 * 64'(2 * k + 1)) >> (TABLE_BITS + 1);
			s = (sine_q30(a) + 64'(1 << 14)) >> 15;
			r[k] = (s > 64'(SAMPLE_MAX)) ? SINE_W'(SAMPLE_MAX) : SINE_W'(s);
		end
		return r;
	endfunction

	localparam rom_arr_t SINE_ROM = build_rom();

	always_ff @(posedge clk) begin
		data <= SINE_ROM[addr];
	end

endmodule
